>>> sv/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared types and constants for the set-associative TLB with LRU replacement.
// ----------------------------------------------------------------------------
package tlbl_pkg;

	localparam int PAGE_W       = 52;
	localparam int STAMP_W      = 32;
	localparam int DEF_NUM_SETS = 16;
	localparam int DEF_NUM_WAYS = 4;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		op_t               op;
		logic              upd;
		logic [PAGE_W-1:0] ppage;
		logic [PAGE_W-1:0] vpage;
	} req_t;

	typedef enum logic {
		B_IDLE = 1'b0,
		B_LOOK = 1'b1
	} bst_t;

endpackage

>>> sv/set_assoc_tlb_lru_core.sv
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_core
// Set-associative translation buffer with least recently used replacement.
// ----------------------------------------------------------------------------
// An accepted input word passes through the front end's set computation, a
// remainder by the set count unless that count is a power of two, then the queue,
// the back end's registered set read, and compare and write back, which load the
// result register. The front end takes no new word until it has queued the last one,
// and the back end takes none until it has written back the last one.
// Reset clears every valid bit at once and sets the use counter to one.
module set_assoc_tlb_lru_core #(
	parameter int NUM_SETS = tlbl_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS = tlbl_pkg::DEF_NUM_WAYS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,  // virt_page [51:0], phys_page_in [103:52], update_recency [104]
	input  logic [1:0]    s_tuser,  // opcode
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [55:0]   m_tdata,  // phys_page_out [51:0]
	output logic          m_tuser   // hit
);

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

	// The front classifies each word and computes its set; the back owns
	// the set memories. The queue between them lets either side stall.
	logic                q_valid;
	logic                q_ready;
	tlbl_pkg::req_t      q_req;
	logic [SET_W-1:0]    q_set;

	tlbl_front #(.NUM_SETS(NUM_SETS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req),
		.q_set    (q_set)
	);

	tlbl_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req),
		.q_set    (q_set),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The back never takes words back to back.
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> !(q_valid && q_ready))
		else $error("back end took words on consecutive cycles");

	// A new result appears only after the back took a word and read and compared its set.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(q_valid && q_ready, 2))
		else $error("result word without a matching request");

	// The back only takes a word when the result register is free or drains.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> (!m_tvalid || m_tready))
		else $error("request taken while result stalled");

endmodule

>>> sv/tlbl_front.sv
// ----------------------------------------------------------------------------
// tlbl_front
// Accepts request words, works out the set index and queues the request.
// ----------------------------------------------------------------------------
module tlbl_front #(
	parameter int NUM_SETS = tlbl_pkg::DEF_NUM_SETS,
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [111:0]        s_tdata,  // virt_page, phys_page_in, update_recency, zero fill
	input  logic [1:0]          s_tuser,  // opcode
	output logic                q_valid,
	input  logic                q_ready,
	output tlbl_pkg::req_t      q_req,
	output logic [SET_W-1:0]    q_set
);

	localparam bit POW2   = ((NUM_SETS & (NUM_SETS - 1)) == 0);
	localparam int DIGITS = 8;
	localparam int STEPS  = 7;
	localparam int SH_W   = DIGITS * STEPS;
	localparam int R_W    = SET_W + 1;

	logic                busy_q;
	tlbl_pkg::req_t      req_q;
	logic [2:0]          cnt_q;
	logic [SH_W-1:0]     sh_q;
	logic [R_W-1:0]      rem_q;
	logic [R_W-1:0]      rem_nxt;
	logic                done;
	logic                push;
	logic                accept;
	logic [SET_W-1:0]    set_res;

	tlbl_pkg::req_t      ent_req_q [2];
	logic [SET_W-1:0]    ent_set_q [2];
	logic                wp_q;
	logic                rp_q;
	logic [1:0]          fill_q;
	logic                pop;

	// Remainder by the set count, eight bits a cycle, most significant first.
	always_comb begin
		logic [R_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGITS; i++) begin
			r = {r[SET_W-1:0], sh_q[SH_W-1-i]};
			if (r >= R_W'(NUM_SETS)) begin
				r = r - R_W'(NUM_SETS);
			end
		end
		rem_nxt = r;
	end

	assign done    = POW2 ? 1'b1 : (cnt_q == 3'(STEPS));
	assign set_res = POW2 ? (SET_W'(req_q.vpage) & SET_W'(NUM_SETS - 1)) : rem_q[SET_W-1:0];
	assign push    = busy_q & done & (fill_q != 2'd2);
	assign s_tready = ~busy_q | push;
	assign accept  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (push) begin
			busy_q <= 1'b0;
		end else if (busy_q && !done) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op    <= tlbl_pkg::op_t'(s_tuser);
			req_q.vpage <= s_tdata[51:0];
			req_q.ppage <= s_tdata[103:52];
			req_q.upd   <= s_tdata[104];
			sh_q        <= {4'b0, s_tdata[51:0]};
			rem_q       <= '0;
		end else if (busy_q && !done) begin
			sh_q  <= sh_q << DIGITS;
			rem_q <= rem_nxt;
		end
	end

	// Two-entry queue toward the back.
	assign q_valid = (fill_q != 2'd0);
	assign pop     = q_valid & q_ready;
	assign q_req   = ent_req_q[rp_q];
	assign q_set   = ent_set_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_req_q[wp_q] <= req_q;
			ent_set_q[wp_q] <= set_res;
		end
	end

endmodule

>>> sv/tlbl_back.sv
// ----------------------------------------------------------------------------
// tlbl_back
// Reads a set, compares tags, picks a victim, writes the set back and
// holds the result word.
// ----------------------------------------------------------------------------
module tlbl_back #(
	parameter int NUM_SETS = tlbl_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS = tlbl_pkg::DEF_NUM_WAYS,
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  tlbl_pkg::req_t      q_req,
	input  logic [SET_W-1:0]    q_set,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [55:0]         m_tdata,  // phys_page_out, zero fill
	output logic                m_tuser   // hit
);

	localparam int PW = tlbl_pkg::PAGE_W;
	localparam int SW = tlbl_pkg::STAMP_W;

	typedef logic [NUM_WAYS-1:0][PW-1:0] prow_t;
	typedef logic [NUM_WAYS-1:0][SW-1:0] srow_t;

	prow_t                tag_mem   [NUM_SETS];
	prow_t                page_mem  [NUM_SETS];
	srow_t                stamp_mem [NUM_SETS];
	logic [NUM_WAYS-1:0]  valid_q   [NUM_SETS];

	tlbl_pkg::bst_t       state_q, state_nxt;
	tlbl_pkg::req_t       req_s1;
	logic [SET_W-1:0]     set_s1;
	prow_t                tag_s1, page_s1;
	srow_t                stamp_s1;
	logic [SW-1:0]        ctr_q;

	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [PW-1:0]        out_page_q;

	logic                 pop;
	logic [NUM_WAYS-1:0]  vrow;
	logic                 hit;
	logic [WAY_W-1:0]     hit_way;
	logic [WAY_W-1:0]     victim;
	logic                 mark;
	logic [WAY_W-1:0]     mark_way;
	logic                 fill;
	logic                 do_flush;
	prow_t                tag_new, page_new;
	srow_t                stamp_new;

	assign pop = q_valid & q_ready;

	always_comb begin
		state_nxt = state_q;
		q_ready   = 1'b0;
		unique case (state_q)
			tlbl_pkg::B_IDLE: begin
				q_ready = ~out_valid_q | m_tready;
				if (q_valid && q_ready) begin
					state_nxt = tlbl_pkg::B_LOOK;
				end
			end
			tlbl_pkg::B_LOOK: begin
				state_nxt = tlbl_pkg::B_IDLE;
			end
			default: state_nxt = tlbl_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbl_pkg::B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Set read, registered.
	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1   <= q_req;
			set_s1   <= q_set;
			tag_s1   <= tag_mem[q_set];
			page_s1  <= page_mem[q_set];
			stamp_s1 <= stamp_mem[q_set];
		end
	end

	// Tag compare and victim choice over the ways of the set.
	always_comb begin
		logic             free_found;
		logic [SW-1:0]    best_stamp;
		vrow       = valid_q[set_s1];
		hit        = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		victim     = '0;
		best_stamp = stamp_s1[0];
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!hit && vrow[w] && tag_s1[w] == req_s1.vpage) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!free_found) begin
				if (!vrow[w]) begin
					free_found = 1'b1;
					victim     = WAY_W'(w);
				end else if (stamp_s1[w] < best_stamp) begin
					victim     = WAY_W'(w);
					best_stamp = stamp_s1[w];
				end
			end
		end
	end

	always_comb begin
		mark     = 1'b0;
		fill     = 1'b0;
		do_flush = 1'b0;
		mark_way = hit_way;
		case (req_s1.op)
			tlbl_pkg::OP_LOOKUP: mark = hit & req_s1.upd;
			tlbl_pkg::OP_INSERT: begin
				fill     = ~hit;
				mark     = ~hit;
				mark_way = victim;
			end
			tlbl_pkg::OP_FLUSH: do_flush = 1'b1;
			default: ;
		endcase
		tag_new   = tag_s1;
		page_new  = page_s1;
		stamp_new = stamp_s1;
		if (fill) begin
			tag_new[mark_way]  = req_s1.vpage;
			page_new[mark_way] = req_s1.ppage;
		end
		if (mark) begin
			stamp_new[mark_way] = ctr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlbl_pkg::B_LOOK && (mark || fill)) begin
			tag_mem[set_s1]   <= tag_new;
			page_mem[set_s1]  <= page_new;
			stamp_mem[set_s1] <= stamp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
			end
			ctr_q <= SW'(1);
		end else if (state_q == tlbl_pkg::B_LOOK) begin
			if (do_flush) begin
				for (int s = 0; s < NUM_SETS; s++) begin
					valid_q[s] <= '0;
				end
			end else if (fill) begin
				valid_q[set_s1][mark_way] <= 1'b1;
			end
			if (mark && ctr_q != '1) begin
				ctr_q <= ctr_q + SW'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tlbl_pkg::B_LOOK) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlbl_pkg::B_LOOK) begin
			out_hit_q  <= hit & (req_s1.op == tlbl_pkg::OP_LOOKUP ||
				req_s1.op == tlbl_pkg::OP_INSERT);
			out_page_q <= (hit && (req_s1.op == tlbl_pkg::OP_LOOKUP ||
				req_s1.op == tlbl_pkg::OP_INSERT)) ? page_s1[hit_way] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {4'b0, out_page_q};

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for set_assoc_tlb_lru_core. A queue-fed driver offers
// lookup, insert, flush and idle words. A tracking model of the sets and use
// stamps predicts every result word, and a monitor checks them in order.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS    = tlbl_pkg::DEF_NUM_SETS;
	localparam int WAYS    = tlbl_pkg::DEF_NUM_WAYS;
	localparam int ENTRIES = SETS * WAYS;
	localparam int PAGE_W  = tlbl_pkg::PAGE_W;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		tlbl_pkg::op_t     op;
		logic              upd;
		logic [PAGE_W-1:0] ppage;
		logic [PAGE_W-1:0] vpage;
	} tlb_word_t;

	typedef struct packed {
		logic              hit;
		logic [PAGE_W-1:0] page;
	} xlate_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         m_tuser;

	set_assoc_tlb_lru_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Shadow copy of the translation table.
	logic              shadow_valid [ENTRIES];
	logic [PAGE_W-1:0] shadow_tag   [ENTRIES];
	logic [PAGE_W-1:0] shadow_page  [ENTRIES];
	logic [31:0]       shadow_stamp [ENTRIES];
	logic [31:0]       shadow_clock;

	tlb_word_t pending_words [$];
	xlate_t    expected_xlates [$];

	int  send_idle_pct;   // chance in a hundred that the sender holds off
	int  recv_stall_pct;  // chance in a hundred that the receiver stalls
	bit  recv_hold;       // long receiver hold-off
	int  errors;
	int  quiet_cycles;
	bit  stim_done;

	// Stamp an entry as most recently used; the clock saturates.
	function automatic void touch(int idx);
		shadow_stamp[idx] = shadow_clock;
		if (shadow_clock != 32'hFFFF_FFFF)
			shadow_clock = shadow_clock + 1;
	endfunction

	// Predict the translation result of one word and advance the shadow table.
	function automatic xlate_t translate(tlb_word_t w);
		xlate_t r;
		int base;
		int way;
		int victim;
		logic [31:0] oldest;
		r = '0;
		base = int'(w.vpage % SETS) * WAYS;
		way = -1;
		for (int i = 0; i < WAYS; i++)
			if (way < 0 && shadow_valid[base+i] && shadow_tag[base+i] == w.vpage)
				way = i;
		case (w.op)
			tlbl_pkg::OP_LOOKUP: begin
				if (way >= 0) begin
					r.hit = 1'b1;
					r.page = shadow_page[base+way];
					if (w.upd)
						touch(base + way);
				end
			end
			tlbl_pkg::OP_INSERT: begin
				if (way >= 0) begin
					r.hit = 1'b1;
					r.page = shadow_page[base+way];
				end else begin
					victim = -1;
					oldest = '0;
					for (int i = 0; i < WAYS; i++) begin
						if (victim < 0 || shadow_valid[base+victim]) begin
							if (!shadow_valid[base+i]) begin
								victim = i;
							end else if (victim < 0 || shadow_stamp[base+i] < oldest) begin
								victim = i;
								oldest = shadow_stamp[base+i];
							end
						end
					end
					shadow_tag[base+victim] = w.vpage;
					shadow_page[base+victim] = w.ppage;
					shadow_valid[base+victim] = 1'b1;
					touch(base + victim);
				end
			end
			tlbl_pkg::OP_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++)
					shadow_valid[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Driver: offers words from the pending queue, with random idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= tlbl_pkg::OP_LOOKUP;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_xlates.insert(expected_xlates.size(),
					translate(pending_words.pop_front()));
			end
			if ((!s_tvalid || s_tready) ) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'd0, pending_words[0].upd, pending_words[0].ppage,
						pending_words[0].vpage};
					s_tuser  <= pending_words[0].op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with random stalls and an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		xlate_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_xlates.size() == 0) begin
				$error("result word with no prediction waiting");
				errors++;
			end else begin
				exp_r = expected_xlates.pop_front();
				if (m_tuser !== exp_r.hit) begin
					$error("hit: expected %0d, actual %0d", exp_r.hit, m_tuser);
					errors++;
				end
				if (m_tdata[PAGE_W-1:0] !== exp_r.page) begin
					$error("phys_page_out: expected %h, actual %h", exp_r.page,
						m_tdata[PAGE_W-1:0]);
					errors++;
				end
			end
		end
	end

	// Watchdog over cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || recv_hold)
			quiet_cycles <= 0;
		else if (pending_words.size() > 0 || expected_xlates.size() > 0 || !stim_done)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("set_assoc_tlb_lru_core regression: fail");
			$finish;
		end
	end

	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'({$urandom(), $urandom()});
	endfunction

	// Virtual pages drawn from a small pool so sets fill up and hits recur.
	function automatic logic [PAGE_W-1:0] pool_page(int sel);
		return {PAGE_W'(sel) << 4} | PAGE_W'($urandom_range(SETS - 1));
	endfunction

	function automatic tlb_word_t make_word(tlbl_pkg::op_t op, logic [PAGE_W-1:0] vp,
			logic [PAGE_W-1:0] pp, logic upd);
		tlb_word_t w;
		w.op = op;
		w.vpage = vp;
		w.ppage = pp;
		w.upd = upd;
		return w;
	endfunction

	// Appends one word at the tail of the pending queue.
	function automatic void enqueue_word(tlb_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	task automatic queue_random(int count);
		int r;
		tlbl_pkg::op_t op;
		logic [PAGE_W-1:0] vp;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 45)
				op = tlbl_pkg::OP_LOOKUP;
			else if (r < 90)
				op = tlbl_pkg::OP_INSERT;
			else if (r < 97)
				op = tlbl_pkg::OP_NOP;
			else
				op = tlbl_pkg::OP_FLUSH;
			if ($urandom_range(9) < 8)
				vp = pool_page($urandom_range(9));
			else
				vp = rand_page();
			enqueue_word(make_word(op, vp, rand_page(), 1'($urandom_range(1))));
		end
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || expected_xlates.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = tlbl_pkg::OP_LOOKUP;
		m_tready = 1'b0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		errors = 0;
		quiet_cycles = 0;
		stim_done = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i] = '0;
			shadow_page[i] = '0;
			shadow_stamp[i] = '0;
		end
		shadow_clock = 32'd1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n = 1'b1;

		// Directed: empty lookup, extremes of pages, set fill, eviction with refresh,
		// insert that hits, lookup without recency, unused opcode and flush.
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, '0, '0, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, '1, '1, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, '1, '0, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, '0, '1, 1'b1));
		for (int i = 1; i <= 4; i++)
			enqueue_word(make_word(tlbl_pkg::OP_INSERT, PAGE_W'(i * SETS + 3),
				PAGE_W'(i * 100), 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, PAGE_W'(SETS + 3), '0, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, PAGE_W'(2 * SETS + 3), '0, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, PAGE_W'(2 * SETS + 3), '1, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, PAGE_W'(5 * SETS + 3), 52'h5, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, PAGE_W'(6 * SETS + 3), 52'h6, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, PAGE_W'(SETS + 3), '0, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_NOP, '1, '1, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, '1, '0, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_FLUSH, '1, '1, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, '1, '0, 1'b1));
		enqueue_word(make_word(tlbl_pkg::OP_INSERT, '1, 52'hA5A5, 1'b0));
		enqueue_word(make_word(tlbl_pkg::OP_LOOKUP, '1, '0, 1'b1));
		drain();

		// Random phases across the idling mixes.
		queue_random(300);
		drain();
		send_idle_pct = 62;
		queue_random(300);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 62;
		queue_random(300);
		drain();
		send_idle_pct = 35;
		recv_stall_pct = 35;
		queue_random(300);
		drain();

		// Back pressure: the receiver holds off while the sender keeps offering.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b1;
		queue_random(200);
		repeat (300) @(posedge clk);
		recv_hold = 1'b0;
		drain();

		stim_done = 1'b1;
		if (errors == 0)
			$display("set_assoc_tlb_lru_core regression: pass");
		else
			$display("set_assoc_tlb_lru_core regression: fail");
		$finish;
	end

endmodule
